// ===== hdl/sfm_pkg.sv =====
package sfm_pkg;

    localparam int MAX_NEEDLE_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int NEEDLE_BYTES = 32;
    localparam int NEEDLE_WORDS = 4;
    localparam int WORD_W       = 64;
    localparam int NEEDLE_IDX_W = $clog2(NEEDLE_BYTES);
    localparam int LEN_W        = 6;
    localparam int OUT_OFF_W    = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [OUT_OFF_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_3 = 3'd4;

    typedef logic [7:0] byte_t;
    typedef byte_t [NEEDLE_BYTES-1:0] needle_t;

    typedef struct packed {
        logic advance;
        logic flush;
    } sfm_win_ctrl_t;

endpackage

// ===== hdl/sfm_hay_if.sv =====
interface sfm_hay_if;
    import sfm_pkg::*;

    logic  valid;
    logic  ready;
    byte_t hay_byte;
    logic  end_of_haystack;

    modport source (output valid, output hay_byte, output end_of_haystack, input ready);
    modport sink   (input valid, input hay_byte, input end_of_haystack, output ready);
endinterface

// ===== hdl/sfm_res_if.sv =====
interface sfm_res_if;
    import sfm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_OFF_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== hdl/sfm_cfg_if.sv =====
interface sfm_cfg_if;
    import sfm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ===== hdl/substring_first_match_unit.sv =====
// First-match substring search over a streamed haystack.
// cfg: register writes (needle length, four needle words), always ready;
//   write only while no search transaction is in flight.
// hay: one haystack byte per transaction, end_of_haystack on the final byte.
// res: at most one transaction per search: found=1 with the start offset of
//   the first match, or found=0 with offset 0 if the haystack ends unmatched.
// Throughput: one byte per cycle unless a stalled result holds hay.ready low.
//   The row of compare cells sees the shifted window in the accept cycle, so
//   the decision and the counter update happen in that same cycle.
// A result is visible the cycle after the byte that causes it.
// The single output register accepts a new byte while its content is being
//   taken; if the receiver stalls with a result pending, hay.ready drops
//   until it is taken.
// Reset clears the window, byte counter, match flag, res.valid and the
//   needle registers (length 0). The byte counter saturates at its maximum.
module substring_first_match_unit #(
    parameter int MAX_NEEDLE  = sfm_pkg::MAX_NEEDLE_DEF,
    parameter int OFFSET_BITS = sfm_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfm_hay_if.sink     hay,
    sfm_res_if.source   res,
    sfm_cfg_if.sink     cfg
);
    import sfm_pkg::*;

    localparam int WIDE_W = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;

    logic [LEN_W-1:0]       len_cfg_reg;
    logic [WORD_W-1:0]      word_reg [NEEDLE_WORDS];
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;
    logic                   reported_reg;
    logic                   reported_next;
    logic                   res_valid_reg;
    logic                   res_found_reg;
    logic [OUT_OFF_W-1:0]   res_offset_reg;

    needle_t                needle;
    logic [LEN_W-1:0]       len_eff;
    sfm_win_ctrl_t          win_ctrl;
    logic                   accept;
    logic                   last;
    logic                   all_match;
    logic                   saturated;
    logic                   hit;
    logic                   emit;
    logic [OFFSET_BITS-1:0] off_raw;
    logic [WIDE_W-1:0]      off_wide;
    logic [OUT_OFF_W-1:0]   off_out;

    assign needle  = {word_reg[3], word_reg[2], word_reg[1], word_reg[0]};
    assign len_eff = (len_cfg_reg > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : len_cfg_reg;

    assign hay.ready = !res_valid_reg || res.ready;
    assign cfg.ready = 1'b1;
    assign accept    = hay.valid && hay.ready;
    assign last      = hay.end_of_haystack;

    assign win_ctrl.advance = accept;
    assign win_ctrl.flush   = last;

    sfm_window #(.MAX_NEEDLE(MAX_NEEDLE)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .hay_byte  (hay.hay_byte),
        .needle    (needle),
        .len_eff   (len_eff),
        .all_match (all_match)
    );

    always_comb
    begin
        saturated = (cnt_reg == '1);
        cnt_next  = saturated ? cnt_reg : cnt_reg + OFFSET_BITS'(1);
        off_raw   = cnt_next - OFFSET_BITS'(len_eff);
        off_wide  = WIDE_W'(off_raw);
        if (saturated || (off_wide > WIDE_W'(OUT_MAX)))
        begin
            off_out = OUT_MAX;
        end
        else
        begin
            off_out = off_wide[OUT_OFF_W-1:0];
        end
        if (len_eff == '0)
        begin
            hit     = 1'b1;
            off_out = '0;
        end
        else
        begin
            hit = (cnt_next >= OFFSET_BITS'(len_eff)) && all_match;
        end
        emit          = !reported_reg && (hit || last);
        reported_next = last ? 1'b0 : (reported_reg || hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= '0;
            for (int w = 0; w < NEEDLE_WORDS; w++)
            begin
                word_reg[w] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_NEEDLE_LENGTH: len_cfg_reg <= cfg.data[LEN_W-1:0];
                REG_NEEDLE_WORD_0: word_reg[0] <= cfg.data;
                REG_NEEDLE_WORD_1: word_reg[1] <= cfg.data;
                REG_NEEDLE_WORD_2: word_reg[2] <= cfg.data;
                REG_NEEDLE_WORD_3: word_reg[3] <= cfg.data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg      <= last ? '0 : cnt_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_found_reg  <= hit;
            res_offset_reg <= hit ? off_out : '0;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.found        = res_found_reg;
    assign res.match_offset = res_offset_reg;

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> cnt_reg == '0 && !reported_reg)
        else $error("search state not cleared after final byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last && cnt_reg != '1 |=> cnt_reg == $past(cnt_reg) + OFFSET_BITS'(1))
        else $error("byte counter did not advance");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && reported_reg |=> !res_valid_reg || $past(res_valid_reg && !res.ready))
        else $error("result issued after match already reported");

    a_empty_needle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && len_eff == '0 && !reported_reg
        |=> res_valid_reg && res_found_reg && res_offset_reg == '0)
        else $error("empty needle did not match at offset zero");

endmodule

// ===== hdl/sfm_cell.sv =====
module sfm_cell #(
    parameter int POS = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfm_pkg::sfm_win_ctrl_t       ctrl,
    input  sfm_pkg::byte_t               byte_in,
    input  sfm_pkg::needle_t             needle,
    input  logic [sfm_pkg::LEN_W-1:0]    len_eff,
    output sfm_pkg::byte_t               byte_out,
    output logic                         match
);
    import sfm_pkg::*;

    byte_t                   data_reg;
    logic                    active;
    logic [LEN_W-1:0]        sel_full;
    logic [NEEDLE_IDX_W-1:0] sel;

    // cell POS compares against needle byte len-1-POS
    assign active   = LEN_W'(POS) < len_eff;
    assign sel_full = len_eff - LEN_W'(POS) - LEN_W'(1);
    assign sel      = sel_full[NEEDLE_IDX_W-1:0];
    assign match    = !active || (byte_in == needle[sel]);
    assign byte_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            data_reg <= ctrl.flush ? byte_t'(0) : byte_in;
        end
    end

endmodule

// ===== hdl/sfm_window.sv =====
module sfm_window #(
    parameter int MAX_NEEDLE = sfm_pkg::MAX_NEEDLE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfm_pkg::sfm_win_ctrl_t       ctrl,
    input  sfm_pkg::byte_t               hay_byte,
    input  sfm_pkg::needle_t             needle,
    input  logic [sfm_pkg::LEN_W-1:0]    len_eff,
    output logic                         all_match
);
    import sfm_pkg::*;

    byte_t                 chain [MAX_NEEDLE+1];
    logic [MAX_NEEDLE-1:0] cell_match;

    assign chain[0]  = hay_byte;
    assign all_match = &cell_match;

    for (genvar k = 0; k < MAX_NEEDLE; k++)
    begin : g_cell
        sfm_cell #(.POS(k)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (chain[k]),
            .needle   (needle),
            .len_eff  (len_eff),
            .byte_out (chain[k+1]),
            .match    (cell_match[k])
        );
    end

endmodule
